// File: design/ncc_pkg.sv
// Shared types, operation codes and decode functions for the nibble calculator controller.
// Used by ncc_ctrl, ncc_dpath and nibble_calculator_controller; depends on nothing.
package ncc_pkg;

    // Operation codes as produced by the keypad and remote decoders.
    localparam logic [4:0] OP_NONE  = 5'd0;
    localparam logic [4:0] OP_OR    = 5'd1;
    localparam logic [4:0] OP_SHL   = 5'd2;
    localparam logic [4:0] OP_SHR   = 5'd3;
    localparam logic [4:0] OP_BASE  = 5'd4;
    localparam logic [4:0] OP_CHAIN = 5'd5;
    localparam logic [4:0] OP_CLEAR = 5'd6;
    localparam logic [4:0] OP_ADD   = 5'd9;
    localparam logic [4:0] OP_SUB   = 5'd10;
    localparam logic [4:0] OP_MUL   = 5'd11;
    localparam logic [4:0] OP_DIV   = 5'd12;
    localparam logic [4:0] OP_MOD   = 5'd13;
    localparam logic [4:0] OP_AND   = 5'd14;
    localparam logic [4:0] OP_XOR   = 5'd15;
    localparam logic [4:0] OP_NOT   = 5'd16;

    // Display base codes.
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;

    // Remote code prefix shared by every recognized button.
    localparam logic [15:0] REMOTE_PREFIX = 16'h20DF;

    // Number of restoring division steps for a 4-bit dividend.
    localparam int DIV_STEPS = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture an input transaction
        logic exec;      // decode event, apply toggles, seed the divider
        logic div_step;  // one restoring division step
        logic commit;    // apply the operation, chaining and error handling
        logic digit;     // split the result into high digit and remainder
        logic emit;      // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;  // accepted event with divide or modulo
        logic out_free;  // output register can take a new transaction
    } t_sts;

    // Decoded remote button.
    typedef struct packed {
        logic       hit;
        logic [3:0] tog_a;
        logic [3:0] tog_b;
        logic [4:0] code;
    } t_remote;

    // Keypad operation code: position of the single set key plus one, zero otherwise.
    function automatic logic [4:0] key_code(input logic [15:0] keys);
        logic [4:0] pos;
        pos = OP_NONE;
        if (keys != 16'd0 && (keys & (keys - 16'd1)) == 16'd0) begin
            for (int i = 0; i < 16; i++) begin
                if (keys[i]) begin
                    pos = pos | 5'(i + 1);
                end
            end
        end
        return pos;
    endfunction

    // Remote button decoder.
    function automatic t_remote remote_decode(input logic [31:0] code);
        t_remote r;
        r = '{hit: 1'b1, tog_a: 4'd0, tog_b: 4'd0, code: OP_NONE};
        if (code[31:16] != REMOTE_PREFIX) begin
            r.hit = 1'b0;
        end else begin
            case (code[15:0])
                16'h08F7: r.tog_a = 4'b0001;
                16'h18E7: r.tog_a = 4'b0010;
                16'hA857: r.tog_a = 4'b0100;
                16'h48B7: r.tog_a = 4'b1000;
                16'hCA35: r.tog_b = 4'b0001;
                16'hE817: r.tog_b = 4'b0010;
                16'h28D7: r.tog_b = 4'b0100;
                16'h8877: r.tog_b = 4'b1000;
                16'h827D: r.code = OP_OR;
                16'h00FF: r.code = OP_SHL;
                16'h807F: r.code = OP_SHR;
                16'h7887: r.code = OP_BASE;
                16'h906F: r.code = OP_CHAIN;
                16'h22DD: r.code = OP_CLEAR;
                16'h40BF: r.code = OP_ADD;
                16'hC03F: r.code = OP_SUB;
                16'h0CF3: r.code = OP_MUL;
                16'h06F9: r.code = OP_DIV;
                16'hDA25: r.code = OP_MOD;
                16'h02FD: r.code = OP_AND;
                16'h609F: r.code = OP_XOR;
                16'hE01F: r.code = OP_NOT;
                default:  r.hit = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

// File: design/nibble_calculator_controller.sv
// Sequence: an accepted transaction passes decode, the divider state, commit, digit split and
// the output load before its result is in the output register; for divide and modulo the
// 4-bit restoring divider takes one quotient bit per cycle in the divider state.
// Flow: one transaction at a time; the input is stalled while one is in work,
// and the load waits as long as the output register holds a stalled transaction.
// Reset: synchronous, active low; clears operands, result, flags and the output valid,
// and sets the greeting flag. No clearing pass is needed.
module nibble_calculator_controller
    import ncc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [23:0] i_scan_word,
    input  logic [31:0] i_remote_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_operand_a,
    output logic [3:0]  o_operand_b,
    output logic [7:0]  o_result_value,
    output logic [1:0]  o_base_mode,
    output logic        o_chain_on,
    output logic        o_error_flag,
    output logic        o_greeting_flag,
    output logic [3:0]  o_digit_hundreds,
    output logic [3:0]  o_digit_tens,
    output logic [3:0]  o_digit_units
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    ncc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Calculator datapath and output register.
    ncc_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_op             (i_op),
        .i_scan_word      (i_scan_word),
        .i_remote_code    (i_remote_code),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_operand_a      (o_operand_a),
        .o_operand_b      (o_operand_b),
        .o_result_value   (o_result_value),
        .o_base_mode      (o_base_mode),
        .o_chain_on       (o_chain_on),
        .o_error_flag     (o_error_flag),
        .o_greeting_flag  (o_greeting_flag),
        .o_digit_hundreds (o_digit_hundreds),
        .o_digit_tens     (o_digit_tens),
        .o_digit_units    (o_digit_units)
    );

endmodule

// File: design/ncc_ctrl.sv
// Controller state machine of the nibble calculator controller.
// Sequences decode, division steps, commit, digit split and output load; uses ncc_pkg.
module ncc_ctrl
    import ncc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_COMMIT,
        S_DIGIT,
        S_EMIT
    } t_state;

    localparam int CNT_W = $clog2(DIV_STEPS);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // Next state and division step count.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_sts.need_div || r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_COMMIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_COMMIT: begin
                n_state = S_DIGIT;
            end
            S_DIGIT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // State register and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Command decode from the current state.
    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.div_step  = (r_state == S_DIV) && i_sts.need_div;
        o_cmd.commit    = (r_state == S_COMMIT);
        o_cmd.digit     = (r_state == S_DIGIT);
        o_cmd.emit      = (r_state == S_EMIT) && i_sts.out_free;
    end

    // The step counter only runs while dividing.
    a_cnt_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_state == S_DIV))
        else $error("division counter running outside the divide state");

    // A loaded transaction always reaches decode on the next cycle.
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("loaded transaction did not proceed to decode");

endmodule

// File: design/ncc_dpath.sv
// Datapath of the nibble calculator controller: calculator state, event decode,
// 4-bit restoring divider, digit split and output register; uses ncc_pkg.
module ncc_dpath
    import ncc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_op,
    input  logic [23:0] i_scan_word,
    input  logic [31:0] i_remote_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_operand_a,
    output logic [3:0]  o_operand_b,
    output logic [7:0]  o_result_value,
    output logic [1:0]  o_base_mode,
    output logic        o_chain_on,
    output logic        o_error_flag,
    output logic        o_greeting_flag,
    output logic [3:0]  o_digit_hundreds,
    output logic [3:0]  o_digit_tens,
    output logic [3:0]  o_digit_units
);

    // Captured transaction.
    logic        r_op;
    logic [23:0] r_scan;
    logic [31:0] r_remote;

    // Calculator state.
    logic [3:0]  r_a, n_a;
    logic [3:0]  r_b, n_b;
    logic [7:0]  r_result, n_result;
    logic [1:0]  r_base, n_base;
    logic        r_chain, n_chain;
    logic        r_err, n_err;
    logic        r_fresh, n_fresh;
    logic [23:0] r_prev, n_prev;

    // Decoded event.
    logic        r_acc, n_acc;
    logic [4:0]  r_code, n_code;

    // Divider working registers.
    logic [3:0]  r_dq;
    logic [3:0]  r_rem;

    // Digit split registers.
    logic [3:0]  r_high;
    logic [7:0]  r_low;

    // Output register.
    logic        r_out_valid;
    logic [3:0]  r_o_a, r_o_b;
    logic [7:0]  r_o_result;
    logic [1:0]  r_o_base;
    logic        r_o_chain, r_o_err, r_o_fresh;
    logic [3:0]  r_o_h, r_o_t, r_o_u;

    t_remote     w_rem;
    logic [4:0]  w_trial;
    logic        w_fit;
    logic [14:0] w_prod;
    logic [3:0]  w_tens_dec;
    logic [6:0]  w_units_dec;
    logic [3:0]  w_h;
    logic [7:0]  w_low;
    logic [3:0]  w_tens, w_units;

    // Event decode: scan toggles and key code, or remote lookup.
    always_comb begin
        w_rem  = remote_decode(r_remote);
        n_a    = r_a;
        n_b    = r_b;
        n_prev = r_prev;
        n_acc  = 1'b0;
        n_code = OP_NONE;
        if (!r_op) begin
            if (r_scan != r_prev) begin
                n_prev = r_scan;
                n_a    = r_a ^ r_scan[23:20];
                n_b    = r_b ^ r_scan[19:16];
                n_acc  = 1'b1;
                n_code = key_code(r_scan[15:0]);
            end
        end else if (w_rem.hit) begin
            n_a    = r_a ^ w_rem.tog_a;
            n_b    = r_b ^ w_rem.tog_b;
            n_acc  = 1'b1;
            n_code = w_rem.code;
        end
    end

    // One restoring division step.
    always_comb begin
        w_trial = {r_rem, r_dq[3]};
        w_fit   = (w_trial >= {1'b0, r_b});
    end

    // Operation, chaining and error handling for an accepted event.
    always_comb begin
        n_result = r_result;
        n_base   = r_base;
        n_chain  = r_chain;
        n_err    = r_err;
        n_fresh  = r_fresh;
        if (r_acc) begin
            n_fresh = 1'b0;
            n_err   = 1'b0;
            case (r_code)
                OP_OR:    n_result = {4'd0, r_a | r_b};
                OP_SHL:   n_result = {r_result[6:0], 1'b0};
                OP_SHR:   n_result = {1'b0, r_result[7:1]};
                OP_BASE: begin
                    case (r_base)
                        BASE_DEC: n_base = BASE_HEX;
                        BASE_HEX: n_base = BASE_OCT;
                        default:  n_base = BASE_DEC;
                    endcase
                end
                OP_CHAIN: n_chain  = !r_chain;
                OP_CLEAR: n_result = 8'd0;
                OP_ADD:   n_result = {4'd0, r_a} + {4'd0, r_b};
                OP_SUB:   n_result = {4'd0, r_a} - {4'd0, r_b};
                OP_MUL:   n_result = {4'd0, r_a} * {4'd0, r_b};
                OP_DIV, OP_MOD: begin
                    if (r_b != 4'd0) begin
                        n_result = (r_code == OP_DIV) ? {4'd0, r_dq} : {4'd0, r_rem};
                    end else begin
                        n_err   = 1'b1;
                        n_chain = 1'b0;
                    end
                end
                OP_AND:   n_result = {4'd0, r_a & r_b};
                OP_XOR:   n_result = {4'd0, r_a ^ r_b};
                OP_NOT:   n_result = ~r_result;
                default:  n_result = r_result;
            endcase
        end
    end

    // Split the result into the high digit and the remainder below base squared.
    always_comb begin
        case (r_base)
            BASE_HEX: begin
                w_h   = 4'd0;
                w_low = r_result;
            end
            BASE_OCT: begin
                w_h   = {2'd0, r_result[7:6]};
                w_low = {2'd0, r_result[5:0]};
            end
            default: begin
                if (r_result >= 8'd200) begin
                    w_h   = 4'd2;
                    w_low = r_result - 8'd200;
                end else if (r_result >= 8'd100) begin
                    w_h   = 4'd1;
                    w_low = r_result - 8'd100;
                end else begin
                    w_h   = 4'd0;
                    w_low = r_result;
                end
            end
        endcase
    end

    // Low two digits; decimal tens by reciprocal multiply, exact below 100.
    always_comb begin
        w_prod      = 15'(r_low[6:0]) * 15'd205;
        w_tens_dec  = w_prod[14:11];
        w_units_dec = r_low[6:0] - 7'(w_tens_dec) * 7'd10;
        case (r_base)
            BASE_HEX: begin
                w_tens  = r_low[7:4];
                w_units = r_low[3:0];
            end
            BASE_OCT: begin
                w_tens  = {1'b0, r_low[5:3]};
                w_units = {1'b0, r_low[2:0]};
            end
            default: begin
                w_tens  = w_tens_dec;
                w_units = w_units_dec[3:0];
            end
        endcase
    end

    // Transaction capture, decode results and divider registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_scan   <= i_scan_word;
            r_remote <= i_remote_code;
        end
        if (i_cmd.exec) begin
            r_acc  <= n_acc;
            r_code <= n_code;
            r_dq   <= n_a;
            r_rem  <= 4'd0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_fit ? 4'(w_trial - {1'b0, r_b}) : w_trial[3:0];
            r_dq  <= {r_dq[2:0], w_fit};
        end
        if (i_cmd.digit) begin
            r_high <= w_h;
            r_low  <= w_low;
        end
    end

    // Calculator state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a      <= 4'd0;
            r_b      <= 4'd0;
            r_result <= 8'd0;
            r_base   <= BASE_DEC;
            r_chain  <= 1'b0;
            r_err    <= 1'b0;
            r_fresh  <= 1'b1;
            r_prev   <= 24'd0;
        end else if (i_cmd.exec) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_prev <= n_prev;
        end else if (i_cmd.commit) begin
            r_base  <= n_base;
            r_chain <= n_chain;
            r_err   <= n_err;
            r_fresh <= n_fresh;
            if (n_err) begin
                r_a      <= 4'd0;
                r_b      <= 4'd0;
                r_result <= 8'd0;
                r_prev   <= 24'd0;
            end else if (r_acc) begin
                if (n_chain) begin
                    r_a      <= n_result[3:0];
                    r_result <= {4'd0, n_result[3:0]};
                end else begin
                    r_result <= n_result;
                    if (r_code == OP_SHL || r_code == OP_SHR || r_code == OP_CLEAR ||
                        r_code == OP_NOT) begin
                        r_a <= 4'd0;
                    end
                end
                if (r_code == OP_SHL || r_code == OP_SHR || r_code == OP_CLEAR ||
                    r_code == OP_NOT) begin
                    r_b <= 4'd0;
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_a      <= r_a;
            r_o_b      <= r_b;
            r_o_result <= r_result;
            r_o_base   <= r_base;
            r_o_chain  <= r_chain;
            r_o_err    <= r_err;
            r_o_fresh  <= r_fresh;
            r_o_h      <= r_high;
            r_o_t      <= w_tens;
            r_o_u      <= w_units;
        end
    end

    assign o_sts.need_div = r_acc && (r_code == OP_DIV || r_code == OP_MOD);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_operand_a      = r_o_a;
    assign o_operand_b      = r_o_b;
    assign o_result_value   = r_o_result;
    assign o_base_mode      = r_o_base;
    assign o_chain_on       = r_o_chain;
    assign o_error_flag     = r_o_err;
    assign o_greeting_flag  = r_o_fresh;
    assign o_digit_hundreds = r_o_h;
    assign o_digit_tens     = r_o_t;
    assign o_digit_units    = r_o_u;

    // An error state reported to the output has all operands cleared.
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_err) |->
            (r_a == 4'd0 && r_b == 4'd0 && r_result == 8'd0 && r_prev == 24'd0))
        else $error("error reported with operands not cleared");

    // The base selector never reaches the unused code.
    a_base_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base == BASE_DEC || r_base == BASE_HEX || r_base == BASE_OCT))
        else $error("base selector left its cycle");

    // Once cleared, the greeting flag stays cleared until reset.
    a_fresh_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fresh |=> !r_fresh)
        else $error("greeting flag set again without reset");

endmodule
